// ===== src/vcs_pkg.sv =====
// Shared types and constants of the voxel chunk store.
// Depends on nothing; the store module imports it.

package vcs_pkg;

   // chunk footprint: 16 x 16 cells per layer
   localparam int EDGE            = 15;
   localparam int ROW             = 16;
   localparam int CELLS_PER_LAYER = 256;
   localparam int ROW_BITS        = $clog2(ROW);
   localparam int CELL_BITS       = $clog2(CELLS_PER_LAYER);

   localparam int COORD_W = 16;
   localparam int ID_W    = 32;
   localparam int LAYER_W = 12;

   // reset values of the layer registers
   localparam logic signed [LAYER_W-1:0] LOWEST_RST  = 12'sd0;
   localparam logic signed [LAYER_W-1:0] HIGHEST_RST = 12'sd511;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_FILL  = 2'd2,
      KIND_REPL  = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_LOWEST  = 1'b0,
      CSR_HIGHEST = 1'b1
   } csr_index_type;

endpackage

// ===== src/voxel_chunk_store.sv =====
// Voxel chunk store: 16 x 16 x LAYERS cells of 32-bit block ids in one RAM.
// Depends on vcs_pkg (kinds, register indexes, chunk constants).
//
// Channel  | Direction | Ports                          | Contents
// ---------+-----------+--------------------------------+--------------------------------
// req      | in        | req_tvalid/tready/tdata/tuser  | command item (kind in tuser)
// rsp      | out       | rsp_tvalid/tready/tdata/tuser  | read data, status in tuser
// csr      | in        | csr_we/csr_index/csr_wdata     | lowest_layer, highest_layer
//
// Sequence: a write is done in S_PREP; a read goes on through S_RDWAIT (the RAM read
//   is registered), a read outside the chunk straight to S_DONE. A box fill writes
//   one cell per cycle of the clamped box, a replace reads one cell per cycle of the
//   valid layers and then passes S_DRAIN (neither runs when the box or the layers are
//   empty); the single RAM write port sets these rates. One item is worked on at a time.
// Reset: synchronous, clears the control state and loads the layer registers;
//   the RAM is not cleared and must be filled by software before it is read.
// Stalls: a new item is taken while a finished result still waits on rsp.

module voxel_chunk_store #(
   parameter int LAYERS = 512
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] far_x,
   // [79:64] far_y, [95:80] far_z, [127:96] block_value, [159:128] new_value
   input  logic [159:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] read_data
   output logic [31:0] rsp_tdata,
   // [0] status
   output logic [0:0]  rsp_tuser,

   input  logic        csr_we,
   input  vcs_pkg::csr_index_type csr_index,
   input  logic [vcs_pkg::LAYER_W-1:0] csr_wdata
);
   import vcs_pkg::*;

   localparam int LYR_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int ADDR_W = LYR_W + CELL_BITS;
   localparam int DEPTH  = LAYERS * CELLS_PER_LAYER;
   localparam int CMP_W  = COORD_W + 1;
   localparam logic signed [CMP_W-1:0] LAYER_SPAN = CMP_W'(LAYERS - 1);
   localparam logic signed [COORD_W-1:0] EDGE_S   = COORD_W'(EDGE);

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_RDWAIT, S_FILL, S_REPL, S_DRAIN, S_DONE
   } state_type;

   // ---------------------------------------------------------------------
   // Layer registers
   // ---------------------------------------------------------------------
   logic signed [LAYER_W-1:0] lowest_ff, highest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff  <= LOWEST_RST;
         highest_ff <= HIGHEST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOWEST:  lowest_ff  <= csr_wdata;
            CSR_HIGHEST: highest_ff <= csr_wdata;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Held item and sweep state
   // ---------------------------------------------------------------------
   state_type                  state_ff;
   kind_type                   kind_ff;
   logic signed [COORD_W-1:0]  px_ff, py_ff, pz_ff, fx_ff, fy_ff, fz_ff;
   logic [ID_W-1:0]            val_ff, nval_ff;

   logic [ROW_BITS-1:0]        cx_ff, cz_ff, x0_ff, x1_ff, z0_ff, z1_ff;
   logic [LYR_W-1:0]           cy_ff, y1_ff;
   logic [ADDR_W-1:0]          scan_ff, last_ff, rd_addr_ff;
   logic                       rd_pend_ff;

   logic [ID_W-1:0]            res_data_ff;
   logic                       res_status_ff;
   logic                       rsp_valid_ff;
   logic [ID_W-1:0]            rsp_data_ff;
   logic                       rsp_status_ff;

   // ---------------------------------------------------------------------
   // Decode of the held item: bounds, cell address, clamped box
   // ---------------------------------------------------------------------
   logic signed [CMP_W-1:0]   lo_s, hi_s, cap_s, top_s, py_s, ymin_s, ymax_s;
   logic signed [CMP_W-1:0]   y_off, ymin_off, ymax_off, span_s;
   logic signed [COORD_W-1:0] xmin, xmax, zmin, zmax;
   logic                      cell_ok, no_layers, box_empty;
   logic [ADDR_W-1:0]         cell_addr;
   logic [ROW_BITS-1:0]       bx0, bx1, bz0, bz1;
   logic [LYR_W-1:0]          by0, by1;

   always_comb begin
      lo_s  = CMP_W'(lowest_ff);
      hi_s  = CMP_W'(highest_ff);
      cap_s = lo_s + LAYER_SPAN;
      top_s = (hi_s < cap_s) ? hi_s : cap_s;
      no_layers = top_s < lo_s;
      span_s = top_s - lo_s;

      // single cell
      py_s    = CMP_W'(py_ff);
      cell_ok = (px_ff[COORD_W-1:ROW_BITS] == '0) && (pz_ff[COORD_W-1:ROW_BITS] == '0) &&
                (py_s >= lo_s) && (py_s <= top_s);
      y_off     = py_s - lo_s;
      cell_addr = {y_off[LYR_W-1:0], pz_ff[ROW_BITS-1:0], px_ff[ROW_BITS-1:0]};

      // box corners, ordered and clamped
      xmin = (px_ff < fx_ff) ? px_ff : fx_ff;
      xmax = (px_ff < fx_ff) ? fx_ff : px_ff;
      zmin = (pz_ff < fz_ff) ? pz_ff : fz_ff;
      zmax = (pz_ff < fz_ff) ? fz_ff : pz_ff;
      ymin_s = (py_ff < fy_ff) ? CMP_W'(py_ff) : CMP_W'(fy_ff);
      ymax_s = (py_ff < fy_ff) ? CMP_W'(fy_ff) : CMP_W'(py_ff);
      ymin_off = ymin_s - lo_s;
      ymax_off = ymax_s - lo_s;

      box_empty = xmax[COORD_W-1] || (xmin > EDGE_S) ||
                  zmax[COORD_W-1] || (zmin > EDGE_S) ||
                  (ymax_s < lo_s) || (ymin_s > top_s) || no_layers;

      bx0 = xmin[COORD_W-1] ? '0 : xmin[ROW_BITS-1:0];
      bx1 = (xmax > EDGE_S) ? ROW_BITS'(EDGE) : xmax[ROW_BITS-1:0];
      bz0 = zmin[COORD_W-1] ? '0 : zmin[ROW_BITS-1:0];
      bz1 = (zmax > EDGE_S) ? ROW_BITS'(EDGE) : zmax[ROW_BITS-1:0];
      by0 = (ymin_s < lo_s) ? '0 : ymin_off[LYR_W-1:0];
      by1 = (ymax_s > top_s) ? span_s[LYR_W-1:0] : ymax_off[LYR_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Cell RAM: one write port, one registered read port
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]   mem [DEPTH];
   logic [ID_W-1:0]   mem_q_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [ID_W-1:0]   mem_wdata;

   always_comb begin
      mem_re    = (state_ff == S_REPL) ||
                  (state_ff == S_PREP && kind_ff == KIND_READ && cell_ok);
      mem_raddr = (state_ff == S_REPL) ? scan_ff : cell_addr;

      mem_we    = 1'b0;
      mem_waddr = cell_addr;
      mem_wdata = val_ff;
      case (state_ff) inside
         S_PREP: begin
            mem_we = (kind_ff == KIND_WRITE) && cell_ok;
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = {cy_ff, cz_ff, cx_ff};
         end
         S_REPL, S_DRAIN: begin
            // write back the cell read in the previous cycle if it matches
            mem_we    = rd_pend_ff && (mem_q_ff == val_ff);
            mem_waddr = rd_addr_ff;
            mem_wdata = nval_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         rd_pend_ff <= (state_ff == S_REPL);
         rd_addr_ff <= scan_ff;

         // drop the result once taken; the completion state loads the next one
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= kind_type'(req_tuser);
                  px_ff    <= req_tdata[15:0];
                  py_ff    <= req_tdata[31:16];
                  pz_ff    <= req_tdata[47:32];
                  fx_ff    <= req_tdata[63:48];
                  fy_ff    <= req_tdata[79:64];
                  fz_ff    <= req_tdata[95:80];
                  val_ff   <= req_tdata[127:96];
                  nval_ff  <= req_tdata[159:128];
                  state_ff <= S_PREP;
               end
            end

            S_PREP: begin
               res_data_ff   <= '0;
               res_status_ff <= 1'b0;
               unique case (kind_ff)
                  KIND_READ: begin
                     res_status_ff <= !cell_ok;
                     state_ff      <= cell_ok ? S_RDWAIT : S_DONE;
                  end
                  KIND_WRITE: begin
                     res_status_ff <= !cell_ok;
                     state_ff      <= S_DONE;
                  end
                  KIND_FILL: begin
                     x0_ff    <= bx0;
                     x1_ff    <= bx1;
                     z0_ff    <= bz0;
                     z1_ff    <= bz1;
                     y1_ff    <= by1;
                     cx_ff    <= bx0;
                     cz_ff    <= bz0;
                     cy_ff    <= by0;
                     state_ff <= box_empty ? S_DONE : S_FILL;
                  end
                  KIND_REPL: begin
                     scan_ff  <= '0;
                     last_ff  <= {span_s[LYR_W-1:0], {CELL_BITS{1'b1}}};
                     state_ff <= no_layers ? S_DONE : S_REPL;
                  end
               endcase
            end

            S_RDWAIT: begin
               res_data_ff <= mem_q_ff;
               state_ff    <= S_DONE;
            end

            S_FILL: begin
               // advance x, then z, then y
               if (cx_ff != x1_ff) begin
                  cx_ff <= cx_ff + 1'b1;
               end else begin
                  cx_ff <= x0_ff;
                  if (cz_ff != z1_ff) begin
                     cz_ff <= cz_ff + 1'b1;
                  end else begin
                     cz_ff <= z0_ff;
                     if (cy_ff != y1_ff) begin
                        cy_ff <= cy_ff + 1'b1;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
               end
            end

            S_REPL: begin
               if (scan_ff == last_ff) begin
                  state_ff <= S_DRAIN;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end

            S_DRAIN: begin
               state_ff <= S_DONE;
            end

            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= res_data_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_fill_cursor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> cx_ff >= x0_ff && cx_ff <= x1_ff &&
                             cz_ff >= z0_ff && cz_ff <= z1_ff && cy_ff <= y1_ff)
      else $error("fill cursor left the clamped box");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_data_ff == '0)
      else $error("failed item returned nonzero data");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the completion state");

   a_quiet_ram: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE || state_ff == S_DONE || state_ff == S_RDWAIT |-> !mem_we)
      else $error("RAM written while no item is at work");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REPL |-> scan_ff <= last_ff)
      else $error("replace sweep ran past the last valid cell");

endmodule

// ===== bench/voxel_chunk_store_chk.sv =====
// Scoreboard for the voxel chunk store bench: watches req, rsp and csr,
// keeps its own copy of the cells and layer registers, and compares every response.
// Depends on vcs_pkg (kinds, register indexes, chunk constants).
`timescale 1ns / 1ps

module voxel_chunk_store_chk #(
   parameter int LAYERS = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] far_x,
   // [79:64] far_y, [95:80] far_z, [127:96] block_value, [159:128] new_value
   input  logic [159:0]       req_tdata,
   // [1:0] kind
   input  logic [1:0]         req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [31:0] read_data
   input  logic [31:0]        rsp_tdata,
   // [0] status
   input  logic [0:0]         rsp_tuser,
   input  logic               csr_we,
   input  vcs_pkg::csr_index_type      csr_index,
   input  logic [vcs_pkg::LAYER_W-1:0] csr_wdata,
   output int                 errors,
   output int                 pending
);
   import vcs_pkg::*;

   typedef struct {
      logic [ID_W-1:0] read_data;
      logic            status;
   } answer_type;

   logic [ID_W-1:0] cell_copy [LAYERS*CELLS_PER_LAYER];
   int              low_layer;
   int              high_layer;
   answer_type      due_answers[$];

   function automatic int imin(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int imax(int a, int b);
      return (a > b) ? a : b;
   endfunction

   // highest usable layer: the register, or the top of the RAM if the span is too tall
   function automatic int layer_top();
      return imin(high_layer, low_layer + LAYERS - 1);
   endfunction

   function automatic bit in_chunk(int x, int y, int z);
      return x >= 0 && x <= EDGE && z >= 0 && z <= EDGE &&
             y >= low_layer && y <= layer_top();
   endfunction

   function automatic int cell_addr(int x, int y, int z);
      return (y - low_layer) * CELLS_PER_LAYER + z * ROW + x;
   endfunction

   // Apply one command to the cell copy and return the response it must produce.
   function automatic answer_type apply_command(kind_type k, logic [159:0] d);
      int px, py, pz, fx, fy, fz, count;
      int x0, x1, y0, y1, z0, z1;
      logic [ID_W-1:0] val, nval;
      answer_type ans;
      px   = $signed(d[15:0]);
      py   = $signed(d[31:16]);
      pz   = $signed(d[47:32]);
      fx   = $signed(d[63:48]);
      fy   = $signed(d[79:64]);
      fz   = $signed(d[95:80]);
      val  = d[127:96];
      nval = d[159:128];
      ans.read_data = '0;
      ans.status    = 1'b0;
      case (k) inside
         KIND_READ, KIND_WRITE: begin
            if (!in_chunk(px, py, pz))
               ans.status = 1'b1;
            else if (k == KIND_READ)
               ans.read_data = cell_copy[cell_addr(px, py, pz)];
            else
               cell_copy[cell_addr(px, py, pz)] = val;
         end
         KIND_FILL: begin
            // clamp both corners to the chunk; an empty box writes nothing
            x0 = imax(0, imin(px, fx));
            x1 = imin(EDGE, imax(px, fx));
            y0 = imax(low_layer, imin(py, fy));
            y1 = imin(layer_top(), imax(py, fy));
            z0 = imax(0, imin(pz, fz));
            z1 = imin(EDGE, imax(pz, fz));
            for (int y = y0; y <= y1; y++)
               for (int z = z0; z <= z1; z++)
                  for (int x = x0; x <= x1; x++)
                     cell_copy[cell_addr(x, y, z)] = val;
         end
         default: begin
            count = 0;
            if (layer_top() >= low_layer)
               count = (layer_top() - low_layer + 1) * CELLS_PER_LAYER;
            for (int i = 0; i < count; i++)
               if (cell_copy[i] == val)
                  cell_copy[i] = nval;
         end
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 40)
         $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         low_layer  = LOWEST_RST;
         high_layer = HIGHEST_RST;
      end else begin
         // retire responses before taking a new command from the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (due_answers.size() == 0) begin
               report_mismatch("response without command", rsp_tdata, '0);
            end else begin
               want = due_answers.pop_front();
               if (rsp_tdata !== want.read_data)
                  report_mismatch("read_data", rsp_tdata, want.read_data);
               if (rsp_tuser[0] !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_LOWEST)
               low_layer = $signed(csr_wdata);
            else
               high_layer = $signed(csr_wdata);
         end
         if (req_tvalid && req_tready)
            due_answers.push_back(apply_command(kind_type'(req_tuser), req_tdata));
      end
      pending = due_answers.size();
   end

endmodule

// ===== bench/voxel_chunk_store_tb.sv =====
// Top of the voxel chunk store bench: clock, reset, command stimulus, response
// back-pressure and the verdict. Depends on vcs_pkg, voxel_chunk_store and voxel_chunk_store_chk.
`timescale 1ns / 1ps

module voxel_chunk_store_tb;
   import vcs_pkg::*;

   localparam int LAYERS        = 512;
   // a full-chunk sweep runs with no handshake at all
   localparam int QUIET_LIMIT   = 400000;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 140;
   localparam int CHOKE_CYCLES  = 400;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] far_x,
   // [79:64] far_y, [95:80] far_z, [127:96] block_value, [159:128] new_value
   logic [159:0]  req_tdata  = '0;
   // [1:0] kind
   logic [1:0]    req_tuser  = '0;

   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // [31:0] read_data
   logic [31:0]   rsp_tdata;
   // [0] status
   logic [0:0]    rsp_tuser;

   logic               csr_we    = 1'b0;
   csr_index_type      csr_index = CSR_LOWEST;
   logic [LAYER_W-1:0] csr_wdata = '0;

   int errors;
   int pending;

   // idle rates in percent; the receiver's rate is written with NBAs only
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   // long receiver hold-off: stimulus flips choke_req, receiver counts it down
   logic choke_req  = 1'b0;
   logic choke_ack  = 1'b0;
   int   choke_left = 0;

   int quiet_cycles = 0;

   // layer registers as last written, used to aim coordinates at the chunk
   int cfg_lo = 0;
   int cfg_hi = 511;

   // a few recurring ids so that replace finds something to swap
   logic [31:0] palette [8];

   voxel_chunk_store #(.LAYERS(LAYERS)) uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_index, .csr_wdata
   );

   voxel_chunk_store_chk #(.LAYERS(LAYERS)) mirror (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_index, .csr_wdata,
      .errors, .pending
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: drop ready at the chosen rate, or hold it low for a long stretch
   // when asked so that the store backs up and stalls its input.
   always @(posedge clock) begin
      if (choke_req != choke_ack) begin
         choke_ack  <= choke_req;
         choke_left <= CHOKE_CYCLES;
         rsp_tready <= 1'b0;
      end else if (choke_left != 0) begin
         choke_left <= choke_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("voxel_chunk_store_tb: errors");
      $finish;
   end

   // Offer one command and return at the edge that accepts it. Valid stays high
   // on return; the next call lowers it only if it decides to idle first.
   task automatic send_cmd(input kind_type k, input int px, py, pz, fx, fy, fz,
                           input logic [31:0] val, input logic [31:0] nval);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {nval, val, fz[15:0], fy[15:0], fx[15:0], pz[15:0], py[15:0], px[15:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every response is back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
   endtask

   // Rewrite both layer registers with the store idle.
   task automatic set_layers(input int lo, input int hi);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_LOWEST;
      csr_wdata <= lo[LAYER_W-1:0];
      @(posedge clock);
      csr_index <= CSR_HIGHEST;
      csr_wdata <= hi[LAYER_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      cfg_lo = lo;
      cfg_hi = hi;
   endtask

   function automatic int any_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // One random command aimed mostly at and around the chunk; now and then the
   // coordinates span the whole 16-bit range.
   task automatic random_cmd();
      int top, ylo, yhi, px, py, pz, fx, fy, fz, pick;
      bit tall, wide;
      logic [31:0] val, nval;
      kind_type k;
      top  = (cfg_hi < cfg_lo + LAYERS - 1) ? cfg_hi : cfg_lo + LAYERS - 1;
      // on a tall chunk keep sweeps short: no replace, fills a few layers high
      tall = (top - cfg_lo) > 4;
      ylo  = ((cfg_lo < top) ? cfg_lo : top) - 2;
      yhi  = ((cfg_lo > top) ? cfg_lo : top) + 2;
      pick = $urandom_range(0, 99);
      if (pick < 34)
         k = KIND_READ;
      else if (pick < 64)
         k = KIND_WRITE;
      else if (pick < 88 || tall)
         k = KIND_FILL;
      else
         k = KIND_REPL;
      wide = ($urandom_range(0, 9) == 0) && !(tall && k == KIND_FILL);
      if (wide) begin
         px = any_coord();
         py = any_coord();
         pz = any_coord();
         fx = any_coord();
         fy = any_coord();
         fz = any_coord();
      end else begin
         px = int'($urandom_range(0, 21)) - 3;
         pz = int'($urandom_range(0, 21)) - 3;
         py = ylo + int'($urandom_range(0, yhi - ylo));
         fx = int'($urandom_range(0, 21)) - 3;
         fz = int'($urandom_range(0, 21)) - 3;
         fy = py + int'($urandom_range(0, 6)) - 3;
      end
      val  = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 7)] : $urandom;
      nval = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 7)] : $urandom;
      send_cmd(k, px, py, pz, fx, fy, fz, val, nval);
   endtask

   initial begin
      int lo, hi;
      for (int i = 0; i < 8; i++)
         palette[i] = $urandom;
      palette[0] = 32'hCAFE_F00D;
      palette[1] = 32'h0000_0000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, default layers 0..511. Fill the whole RAM first: no cell
      // may be read, or swept by replace, before it has been written.
      send_cmd(KIND_FILL, 0, 0, 0, 15, 511, 15, 32'h5EED_0001, 32'h0);
      send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 32'h0, 32'h0);
      send_cmd(KIND_READ, 15, 511, 15, 0, 0, 0, 32'h0, 32'h0);
      send_cmd(KIND_WRITE, 15, 511, 15, 0, 0, 0, 32'hFFFF_FFFF, 32'h0);
      send_cmd(KIND_READ, 15, 511, 15, 0, 0, 0, 32'h0, 32'h0);
      send_cmd(KIND_WRITE, 0, 0, 0, 0, 0, 0, 32'h0, 32'h0);
      send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 32'h0, 32'h0);
      // one step outside on each x and y face, then the far ends of the coordinate range
      send_cmd(KIND_WRITE, -1, 0, 0, 0, 0, 0, 32'h1111_1111, 32'h0);
      send_cmd(KIND_READ, 16, 0, 0, 0, 0, 0, 32'h0, 32'h0);
      send_cmd(KIND_READ, 0, -1, 0, 0, 0, 0, 32'h0, 32'h0);
      send_cmd(KIND_WRITE, 0, 512, 15, 0, 0, 0, 32'h2222_2222, 32'h0);
      send_cmd(KIND_READ, -32768, 32767, -32768, 32767, -32768, 32767, 32'h0, 32'h0);
      send_cmd(KIND_WRITE, 32767, -32768, 32767, -32768, 32767, -32768,
               32'hA5A5_5A5A, 32'hFFFF_FFFF);
      // corners given partly high-to-low and past the edges: clamps to two full layers
      send_cmd(KIND_FILL, 20, 7, -4, -3, 6, 20, 32'h1234_5678, 32'h0);
      // box wholly beyond x = 15: nothing written
      send_cmd(KIND_FILL, 16, 3, 0, 30, 4, 15, 32'hDEAD_BEEF, 32'h0);
      send_cmd(KIND_READ, 7, 6, 9, 0, 0, 0, 32'h0, 32'h0);
      // full sweep over all 512 layers
      send_cmd(KIND_REPL, 0, 0, 0, 0, 0, 0, 32'h5EED_0001, 32'hCAFE_F00D);
      send_cmd(KIND_READ, 3, 300, 3, 0, 0, 0, 32'h0, 32'h0);

      // inverted layers: no cell is valid, fill and replace do nothing
      set_layers(10, 5);
      send_cmd(KIND_READ, 0, 10, 0, 0, 0, 0, 32'h0, 32'h0);
      send_cmd(KIND_WRITE, 0, 5, 0, 0, 0, 0, 32'h3333_3333, 32'h0);
      send_cmd(KIND_FILL, 0, 0, 0, 15, 20, 15, 32'h4444_4444, 32'h0);
      send_cmd(KIND_REPL, 0, 0, 0, 0, 0, 0, 32'hCAFE_F00D, 32'h5555_5555);

      // span too tall: only LAYERS layers above lowest_layer are inside
      set_layers(-2048, 2047);
      send_cmd(KIND_WRITE, 1, -1537, 1, 0, 0, 0, 32'h6666_6666, 32'h0);
      send_cmd(KIND_WRITE, 1, -1536, 1, 0, 0, 0, 32'h7777_7777, 32'h0);
      send_cmd(KIND_READ, 1, -1537, 1, 0, 0, 0, 32'h0, 32'h0);

      // Random part: each segment gets its own layer setting and idle pattern.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin lo = 0;     hi = 3;     end
            1: begin lo = -2048; hi = -2046; end
            2: begin lo = 2047;  hi = 2047;  end
            3: begin lo = -5;    hi = -2;    end
            4: begin lo = -2048; hi = 2047;  end
            5: begin lo = 2044;  hi = 2047;  end
            default: begin
               lo = int'($urandom_range(0, 4095)) - 2048;
               hi = lo + int'($urandom_range(0, 3));
               if (hi > 2047)
                  hi = 2047;
               if ($urandom_range(0, 5) == 0) begin
                  hi = lo - int'($urandom_range(1, 3));
                  if (hi < -2048)
                     hi = -2048;
               end
            end
         endcase
         set_layers(lo, hi);
         // fast sender with a slow receiver, then the reverse, then full rate
         if (seg < 4) begin
            send_idle_pct = 20;
            rsp_idle_pct <= 84;
         end else if (seg < 8) begin
            send_idle_pct = 84;
            rsp_idle_pct <= 20;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         // hold off the receiver while commands keep coming
         if (seg == 1 || seg == 9)
            choke_req <= ~choke_req;
         repeat (SEGMENT_ITEMS) random_cmd();
      end

      drain();
      repeat (20) @(posedge clock);
      @(negedge clock);
      if (errors == 0)
         $display("voxel_chunk_store_tb: clean");
      else
         $display("voxel_chunk_store_tb: errors");
      $finish;
   end

endmodule
